/* sv/kmr_pkg.sv */
// Package for the keyed message reassembly block.
// Holds the sizes, status codes, item and result types and the state enums.
// No dependencies; the design files use it by scoped names, the testbench imports it.
package kmr_pkg;

    // Table and buffer sizes.
    localparam int SLOTS    = 8;
    localparam int SLOT_W   = 3;
    localparam int MSG_MAX  = 4096;
    localparam int MSG_AW   = 12;
    localparam int MEM_AW   = SLOT_W + MSG_AW;
    localparam int MEM_DEPTH = SLOTS * MSG_MAX;
    localparam int LEN_W    = 13;

    // Configuration port.
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 32;
    localparam logic [CFG_AW-1:0] CFG_ADDR_CHUNK_SIZE = 3'd0;
    localparam logic [LEN_W-1:0] CHUNK_SIZE_RESET = 13'd504;
    localparam logic [LEN_W-1:0] MSG_MAX_LEN = 13'd4096;

    // Result status codes.
    localparam logic [2:0] ST_INCOMPLETE = 3'd0;
    localparam logic [2:0] ST_COMPLETE   = 3'd1;
    localparam logic [2:0] ST_LEN_MISM   = 3'd2;
    localparam logic [2:0] ST_BAD_OFFSET = 3'd3;
    localparam logic [2:0] ST_BAD_SUM    = 3'd4;
    localparam logic [2:0] ST_FULL       = 3'd5;
    localparam logic [2:0] ST_UNKNOWN    = 3'd6;
    localparam logic [2:0] ST_UNFINISHED = 3'd7;

    // Request type codes as they arrive on the item.
    localparam logic [1:0] RT_SAVE  = 2'd0;
    localparam logic [1:0] RT_QUERY = 2'd1;
    localparam logic [1:0] RT_READ  = 2'd2;

    // One input item.
    typedef struct packed {
        logic [1:0]       req_type;
        logic [7:0]       msg_cmd;
        logic [15:0]      msg_index;
        logic [LEN_W-1:0] total_len;
        logic [MSG_AW-1:0] chunk_offset;
        logic [LEN_W-1:0] chunk_len;
        logic [MSG_AW-1:0] byte_pos;
        logic [7:0]       data_byte;
        logic             last_flag;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic [2:0]       status;
        logic [LEN_W-1:0] length_out;
        logic [7:0]       read_byte;
    } t_result;

    // Request class decided by the front end.
    typedef enum logic [1:0] {
        REQ_SAVE,
        REQ_QUERY,
        REQ_READ,
        REQ_NONE
    } t_req;

    // Status of the front queue head, seen by the back end.
    typedef struct packed {
        logic valid;
        t_req kind;
    } t_fq_stat;

    // Back end sequencer states.
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SAVE,
        BK_SUM,
        BK_RD
    } t_bk_state;

endpackage

/* sv/kmr_front.sv */
// Front end of the keyed message reassembly block: a two-entry item queue.
// Classifies each item by request type on entry. Depends on kmr_pkg.
module kmr_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  kmr_pkg::t_in_item i_item,
    input  logic              i_pop,
    output kmr_pkg::t_in_item o_head,
    output kmr_pkg::t_fq_stat o_stat
);

    kmr_pkg::t_in_item r_data [2];
    kmr_pkg::t_req     r_kind [2];
    logic              r_wp;
    logic              r_rp;
    logic [1:0]        r_cnt;
    kmr_pkg::t_req     w_kind;
    logic              w_wr;
    logic              w_rd;

    // Classify the incoming item.
    always_comb begin
        case (i_item.req_type)
            kmr_pkg::RT_SAVE:  w_kind = kmr_pkg::REQ_SAVE;
            kmr_pkg::RT_QUERY: w_kind = kmr_pkg::REQ_QUERY;
            kmr_pkg::RT_READ:  w_kind = kmr_pkg::REQ_READ;
            default:           w_kind = kmr_pkg::REQ_NONE;
        endcase
    end

    assign o_full       = (r_cnt == 2'd2);
    assign w_wr         = i_push && !o_full;
    assign w_rd         = i_pop && (r_cnt != 2'd0);
    assign o_head       = r_data[r_rp];
    assign o_stat.valid = (r_cnt != 2'd0);
    assign o_stat.kind  = r_kind[r_rp];

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_data[r_wp] <= i_item;
            r_kind[r_wp] <= w_kind;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wp <= ~r_wp;
            end
            if (w_rd) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_wr} - {1'b0, w_rd};
        end
    end

endmodule

/* sv/kmr_outq.sv */
// Result queue of the keyed message reassembly block, two entries deep.
// Parts the back end from the consumer. Depends on kmr_pkg.
module kmr_outq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  kmr_pkg::t_result i_res,
    output logic             o_full,
    output logic             o_empty,
    input  logic             i_pop,
    output kmr_pkg::t_result o_res
);

    kmr_pkg::t_result r_data [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;
    logic             w_wr;
    logic             w_rd;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_res   = r_data[r_rp];

    // Result storage.
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_data[r_wp] <= i_res;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wp <= ~r_wp;
            end
            if (w_rd) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_wr} - {1'b0, w_rd};
        end
    end

endmodule

/* sv/kmr_back.sv */
// Back end of the keyed message reassembly block: slot table, byte buffer
// and the sequencer that carries out saves, queries, reads and the checksum
// walk. Depends on kmr_pkg.
module kmr_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  kmr_pkg::t_in_item         i_head,
    input  kmr_pkg::t_fq_stat         i_fq,
    output logic                      o_pop,
    input  logic [kmr_pkg::LEN_W-1:0] i_chunk_size,
    input  logic                      i_oq_full,
    output logic                      o_push,
    output kmr_pkg::t_result          o_res
);

    localparam int SW = kmr_pkg::SLOT_W;
    localparam int LW = kmr_pkg::LEN_W;
    localparam int AW = kmr_pkg::MSG_AW;

    // Slot table.
    logic          r_valid [kmr_pkg::SLOTS];
    logic          r_comp  [kmr_pkg::SLOTS];
    logic [7:0]    r_cmd   [kmr_pkg::SLOTS];
    logic [15:0]   r_idx   [kmr_pkg::SLOTS];
    logic [LW-1:0] r_len   [kmr_pkg::SLOTS];

    // Byte buffer.
    logic [7:0] r_mem [kmr_pkg::MEM_DEPTH];
    logic [7:0] r_rdata;

    // Sequencer state.
    kmr_pkg::t_bk_state r_state, n_state;
    kmr_pkg::t_in_item  r_item;
    logic [SW-1:0]      r_active;
    logic [2:0]         r_cs;
    logic [LW-1:0]      r_i;
    logic [7:0]         r_sum;
    logic               r_pend;
    logic [AW-1:0]      r_pidx;
    logic [LW-1:0]      r_lout;
    logic               r_rzero;

    // Lookup results on the queue head.
    logic          w_hit, w_free_any;
    logic [SW-1:0] w_hs, w_fs, w_sel;
    logic          w_eff_comp;
    logic [LW-1:0] w_eff_len, w_fb_len;
    logic          w_setlen;
    logic [2:0]    w_fb_cs;

    // Save stage values.
    logic [SW-1:0] w_s;
    logic [LW-1:0] w_slen, w_lim_base, w_lim, w_addr, w_pos13, w_off13;
    logic          w_live, w_ovr, w_wr;
    logic [LW:0]   w_cnt_end, w_sum_end;
    logic          w_counted_done, w_sum_due;

    // Control decisions.
    logic              w_do_first, w_do_rd, w_do_free, w_do_write, w_do_comp;
    logic              w_start_sum, w_issue, w_sum_last;
    logic [kmr_pkg::MEM_AW-1:0] w_rd_addr;

    // Key match and lowest free slot.
    always_comb begin
        w_hit      = 1'b0;
        w_hs       = '0;
        w_free_any = 1'b0;
        w_fs       = '0;
        for (int s = kmr_pkg::SLOTS - 1; s >= 0; s--) begin
            if (r_valid[s] && r_cmd[s] == i_head.msg_cmd &&
                r_idx[s] == i_head.msg_index) begin
                w_hit = 1'b1;
                w_hs  = SW'(s);
            end
            if (!r_valid[s]) begin
                w_free_any = 1'b1;
                w_fs       = SW'(s);
            end
        end
        w_sel = w_hit ? w_hs : w_fs;
    end

    // First byte checks of a chunk.
    always_comb begin
        w_eff_comp = w_hit && r_comp[w_sel];
        w_eff_len  = w_hit ? r_len[w_sel] : '0;
        w_setlen   = 1'b0;
        w_fb_len   = w_eff_len;
        if (w_eff_comp) begin
            w_fb_cs = kmr_pkg::ST_COMPLETE;
        end else if (i_head.total_len > kmr_pkg::MSG_MAX_LEN) begin
            w_fb_cs = kmr_pkg::ST_LEN_MISM;
        end else begin
            w_setlen = (w_eff_len == '0);
            w_fb_len = w_setlen ? i_head.total_len : w_eff_len;
            if (w_fb_len != i_head.total_len) begin
                w_fb_cs = kmr_pkg::ST_LEN_MISM;
            end else if ({1'b0, i_head.chunk_offset} >= i_head.total_len) begin
                w_fb_cs = kmr_pkg::ST_BAD_OFFSET;
            end else begin
                w_fb_cs = kmr_pkg::ST_INCOMPLETE;
            end
        end
    end

    // Write window and completion tests for the held save item.
    always_comb begin
        w_s        = r_active;
        w_slen     = r_len[w_s];
        w_live     = r_valid[w_s] && !r_comp[w_s];
        w_pos13    = {1'b0, r_item.byte_pos};
        w_off13    = {1'b0, r_item.chunk_offset};
        w_ovr      = w_off13 > w_slen;
        w_lim_base = w_slen - w_off13;
        if (r_item.chunk_len != '0) begin
            w_lim = (w_ovr || r_item.chunk_len < w_lim_base) ? r_item.chunk_len
                                                             : w_lim_base;
            w_addr = w_off13 + w_pos13;
        end else if (w_slen <= i_chunk_size) begin
            w_lim  = w_slen;
            w_addr = w_pos13;
        end else begin
            w_lim = (w_ovr || i_chunk_size < w_lim_base) ? i_chunk_size : w_lim_base;
            w_addr = w_off13 + w_pos13;
        end
        w_wr           = (w_pos13 < w_lim) && !w_addr[LW-1];
        w_cnt_end      = {1'b0, w_off13} + {1'b0, r_item.chunk_len};
        w_sum_end      = {1'b0, w_off13} + {1'b0, i_chunk_size};
        w_counted_done = w_cnt_end >= {1'b0, w_slen};
        w_sum_due      = (w_slen <= i_chunk_size) || (w_sum_end >= {1'b0, w_slen});
    end

    // Next state and results.
    always_comb begin
        n_state     = r_state;
        o_pop       = 1'b0;
        o_push      = 1'b0;
        o_res       = '0;
        w_do_first  = 1'b0;
        w_do_rd     = 1'b0;
        w_do_free   = 1'b0;
        w_do_write  = 1'b0;
        w_do_comp   = 1'b0;
        w_start_sum = 1'b0;
        w_issue     = 1'b0;
        w_sum_last  = 1'b0;
        w_rd_addr   = {w_hs, i_head.byte_pos};
        case (r_state)
            kmr_pkg::BK_IDLE: begin
                if (i_fq.valid && !i_oq_full) begin
                    o_pop = 1'b1;
                    case (i_fq.kind)
                        kmr_pkg::REQ_SAVE: begin
                            n_state    = kmr_pkg::BK_SAVE;
                            w_do_first = (i_head.byte_pos == '0);
                        end
                        kmr_pkg::REQ_QUERY: begin
                            o_push = 1'b1;
                            if (w_hit) begin
                                o_res.status = r_comp[w_hs] ? kmr_pkg::ST_COMPLETE
                                                            : kmr_pkg::ST_UNFINISHED;
                                o_res.length_out = r_len[w_hs];
                            end else begin
                                o_res.status = kmr_pkg::ST_UNKNOWN;
                            end
                        end
                        kmr_pkg::REQ_READ: begin
                            if (!w_hit) begin
                                o_push       = 1'b1;
                                o_res.status = kmr_pkg::ST_UNKNOWN;
                            end else if (!r_comp[w_hs]) begin
                                o_push           = 1'b1;
                                o_res.status     = kmr_pkg::ST_UNFINISHED;
                                o_res.length_out = r_len[w_hs];
                            end else begin
                                n_state   = kmr_pkg::BK_RD;
                                w_do_rd   = 1'b1;
                                w_do_free = i_head.last_flag;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            kmr_pkg::BK_SAVE: begin
                n_state    = kmr_pkg::BK_IDLE;
                w_do_write = (r_cs == kmr_pkg::ST_INCOMPLETE) && w_live && w_wr;
                if (r_item.last_flag) begin
                    o_res.length_out = r_valid[w_s] ? w_slen : '0;
                    if (r_cs != kmr_pkg::ST_INCOMPLETE) begin
                        o_push       = 1'b1;
                        o_res.status = r_cs;
                    end else if (!r_valid[w_s]) begin
                        o_push       = 1'b1;
                        o_res.status = kmr_pkg::ST_UNKNOWN;
                    end else if (r_comp[w_s]) begin
                        o_push       = 1'b1;
                        o_res.status = kmr_pkg::ST_COMPLETE;
                    end else if (r_item.chunk_len != '0) begin
                        o_push       = 1'b1;
                        w_do_comp    = w_counted_done;
                        o_res.status = w_counted_done ? kmr_pkg::ST_COMPLETE
                                                      : kmr_pkg::ST_INCOMPLETE;
                    end else if (w_sum_due) begin
                        if (w_slen == '0) begin
                            o_push       = 1'b1;
                            o_res.status = kmr_pkg::ST_BAD_SUM;
                        end else begin
                            n_state     = kmr_pkg::BK_SUM;
                            w_start_sum = 1'b1;
                        end
                    end else begin
                        o_push       = 1'b1;
                        o_res.status = kmr_pkg::ST_INCOMPLETE;
                    end
                end
            end
            kmr_pkg::BK_SUM: begin
                // Stream bytes 0 to length-1; the last one is the check byte.
                w_rd_addr  = {r_active, r_i[AW-1:0]};
                w_issue    = r_i < w_slen;
                w_sum_last = r_pend && ({1'b0, r_pidx} == w_slen - 1'b1);
                if (w_sum_last) begin
                    n_state          = kmr_pkg::BK_IDLE;
                    o_push           = 1'b1;
                    o_res.length_out = w_slen;
                    w_do_comp        = (r_rdata == r_sum);
                    o_res.status     = (r_rdata == r_sum) ? kmr_pkg::ST_COMPLETE
                                                          : kmr_pkg::ST_BAD_SUM;
                end
            end
            kmr_pkg::BK_RD: begin
                n_state          = kmr_pkg::BK_IDLE;
                o_push           = 1'b1;
                o_res.status     = kmr_pkg::ST_COMPLETE;
                o_res.length_out = r_lout;
                o_res.read_byte  = r_rzero ? 8'd0 : r_rdata;
            end
            default: begin
                n_state = kmr_pkg::BK_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kmr_pkg::BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Byte buffer: one write and one registered read a cycle.
    always_ff @(posedge i_clk) begin
        if (w_do_write) begin
            r_mem[{w_s, w_addr[AW-1:0]}] <= r_item.data_byte;
        end
        r_rdata <= r_mem[w_rd_addr];
    end

    // Held item and checksum walk.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_head;
        end
        if (w_do_rd) begin
            r_lout  <= r_len[w_hs];
            r_rzero <= {1'b0, i_head.byte_pos} >= r_len[w_hs];
        end
        if (w_start_sum) begin
            r_i    <= '0;
            r_sum  <= '0;
            r_pend <= 1'b0;
        end else if (r_state == kmr_pkg::BK_SUM) begin
            r_pend <= w_issue;
            r_pidx <= r_i[AW-1:0];
            if (w_issue) begin
                r_i <= r_i + 1'b1;
            end
            if (r_pend && !w_sum_last) begin
                r_sum <= r_sum + r_rdata;
            end
        end
    end

    // Slot table, active slot and chunk status.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < kmr_pkg::SLOTS; s++) begin
                r_valid[s] <= 1'b0;
                r_comp[s]  <= 1'b0;
                r_len[s]   <= '0;
            end
            r_active <= '0;
            r_cs     <= kmr_pkg::ST_INCOMPLETE;
        end else begin
            if (w_do_first) begin
                if (!w_hit && !w_free_any) begin
                    r_cs <= kmr_pkg::ST_FULL;
                end else begin
                    r_active <= w_sel;
                    r_cs     <= w_fb_cs;
                    if (!w_hit) begin
                        r_valid[w_sel] <= 1'b1;
                        r_cmd[w_sel]   <= i_head.msg_cmd;
                        r_idx[w_sel]   <= i_head.msg_index;
                        r_len[w_sel]   <= '0;
                        r_comp[w_sel]  <= 1'b0;
                    end
                    if (w_setlen) begin
                        r_len[w_sel] <= i_head.total_len;
                    end
                end
            end
            if (w_do_free) begin
                r_valid[w_hs] <= 1'b0;
                r_comp[w_hs]  <= 1'b0;
                r_len[w_hs]   <= '0;
            end
            if (w_do_comp) begin
                r_comp[w_s] <= 1'b1;
            end
        end
    end

endmodule

/* sv/keyed_message_reassembly.sv */
// Keyed message reassembly: chunks of bytes, keyed by command and index, are
// rebuilt into eight slot buffers of 4096 bytes; completed messages are read
// back byte by byte. An item enters a two-entry queue and is carried out one
// at a time by the back sequencer: a save byte does the slot lookup, then the
// buffer write and result; a read does the lookup, then a registered buffer
// read; a query is answered in the lookup step. The last byte of a checksum-
// mode final chunk adds a walk over the slot buffer through its single read
// port. Results wait in a two-entry queue. Buffer bytes are not cleared at
// reset; there is no clearing pass. Depends on kmr_pkg, kmr_front, kmr_back and kmr_outq.
module keyed_message_reassembly (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    output logic                        full,
    input  kmr_pkg::t_in_item           i_item,
    output logic                        empty,
    input  logic                        pop,
    output kmr_pkg::t_result            o_result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [kmr_pkg::CFG_AW-1:0]  paddr,
    input  logic [kmr_pkg::CFG_DW-1:0]  pwdata,
    output logic [kmr_pkg::CFG_DW-1:0]  prdata,
    output logic                        pready
);

    logic [kmr_pkg::LEN_W-1:0] r_chunk_size;
    kmr_pkg::t_in_item         w_head;
    kmr_pkg::t_fq_stat         w_fq;
    logic                      w_pop;
    logic                      w_oq_full;
    logic                      w_push;
    kmr_pkg::t_result          w_res;

    // Configuration register.
    assign pready = 1'b1;
    assign prdata = (paddr == kmr_pkg::CFG_ADDR_CHUNK_SIZE)
                    ? {{(kmr_pkg::CFG_DW - kmr_pkg::LEN_W){1'b0}}, r_chunk_size}
                    : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk_size <= kmr_pkg::CHUNK_SIZE_RESET;
        end else if (psel && penable && pwrite &&
                     paddr == kmr_pkg::CFG_ADDR_CHUNK_SIZE) begin
            r_chunk_size <= pwdata[kmr_pkg::LEN_W-1:0];
        end
    end

    kmr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .i_item  (i_item),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_fq)
    );

    kmr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (w_head),
        .i_fq         (w_fq),
        .o_pop        (w_pop),
        .i_chunk_size (r_chunk_size),
        .i_oq_full    (w_oq_full),
        .o_push       (w_push),
        .o_res        (w_res)
    );

    kmr_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_res   (w_res),
        .o_full  (w_oq_full),
        .o_empty (empty),
        .i_pop   (pop),
        .o_res   (o_result)
    );

endmodule

/* sv/kmr_checker.sv */
// Port-level checks for keyed_message_reassembly, bound to the top level.
// Depends on kmr_pkg and the top level's ports.
module kmr_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       empty,
    input logic                       pop,
    input kmr_pkg::t_result           o_result,
    input logic [kmr_pkg::CFG_DW-1:0] prdata
);

    // Reset leaves no result waiting.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    // Only a completed read carries a byte.
    a_byte_needs_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_result.read_byte == 8'd0 ||
                    o_result.status == kmr_pkg::ST_COMPLETE))
        else $error("read byte on a result that is not complete");

    // An unknown message reports no length.
    a_unknown_no_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.status == kmr_pkg::ST_UNKNOWN) |->
            o_result.length_out == '0)
        else $error("length on unknown message");

    // Register reads never show bits above the chunk size field.
    a_prdata_upper: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        prdata[kmr_pkg::CFG_DW-1:kmr_pkg::LEN_W] == '0)
        else $error("upper register bits set");

    // A waiting result holds until taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_result)))
        else $error("waiting result changed");

endmodule

bind keyed_message_reassembly kmr_checker u_kmr_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .empty    (empty),
    .pop      (pop),
    .o_result (o_result),
    .prdata   (prdata)
);

/* tb/tb_top.sv */
// Self-checking testbench for keyed_message_reassembly: directed table, then random messages.
// Every result is compared with a table expectation or that of a predictor that lives in this file.
// Depends on kmr_pkg and the keyed_message_reassembly RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import kmr_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 1650;
    localparam int POOL_KEYS    = 12;

    // One row of the directed table.
    typedef struct {
        t_in_item item;
        bit       typed;
        t_result  want;
    } t_row;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     push = 1'b0;
    logic     full;
    t_in_item i_item = '0;
    logic     empty;
    logic     pop = 1'b0;
    t_result  o_result;
    logic     psel = 1'b0;
    logic     penable = 1'b0;
    logic     pwrite = 1'b0;
    logic [CFG_AW-1:0] paddr = '0;
    logic [CFG_DW-1:0] pwdata = '0;
    logic [CFG_DW-1:0] prdata;
    logic     pready;

    keyed_message_reassembly i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Clock with a 20 ns period.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Shadow copy of the slot table and buffers.
    logic              slot_used [SLOTS];
    logic [7:0]        slot_cmd [SLOTS];
    logic [15:0]       slot_idx [SLOTS];
    int unsigned       slot_len [SLOTS];
    logic              slot_done [SLOTS];
    logic [7:0]        buf_bytes [MEM_DEPTH];
    bit                buf_written [MEM_DEPTH];
    logic [SLOT_W-1:0] cur_slot;
    logic [2:0]        cur_status;
    int unsigned       chunk_bytes;

    t_result     pending_results[$];
    int          mismatches = 0;
    int          cycles = 0;
    int          items_sent = 0;
    bit          calm = 1'b0;
    logic [7:0]  pool_cmd [POOL_KEYS];
    logic [15:0] pool_idx [POOL_KEYS];

    function automatic int lookup(input logic [7:0] cmd, input logic [15:0] idx);
        for (int s = 0; s < SLOTS; s++) begin
            if (slot_used[s] && slot_cmd[s] == cmd && slot_idx[s] == idx) begin
                return s;
            end
        end
        return -1;
    endfunction

    // Slot selection and chunk checks made on the first byte of a chunk.
    function automatic void open_chunk(input t_in_item it);
        int s;
        s = lookup(it.msg_cmd, it.msg_index);
        if (s < 0) begin
            s = 0;
            while (s < SLOTS && slot_used[s]) s++;
            if (s >= SLOTS) begin
                cur_status = ST_FULL;
                return;
            end
            slot_used[s] = 1'b1;
            slot_cmd[s]  = it.msg_cmd;
            slot_idx[s]  = it.msg_index;
            slot_len[s]  = 0;
            slot_done[s] = 1'b0;
        end
        cur_slot = s[SLOT_W-1:0];
        if (slot_done[s]) begin
            cur_status = ST_COMPLETE;
        end else if (it.total_len > MSG_MAX) begin
            cur_status = ST_LEN_MISM;
        end else begin
            if (slot_len[s] == 0) slot_len[s] = it.total_len;
            if (slot_len[s] != it.total_len) begin
                cur_status = ST_LEN_MISM;
            end else if (it.chunk_offset >= it.total_len) begin
                cur_status = ST_BAD_OFFSET;
            end else begin
                cur_status = ST_INCOMPLETE;
            end
        end
    endfunction

    // Byte save: store the byte, and on the last byte of a chunk decide the outcome.
    function automatic bit save_byte(input t_in_item it, output t_result res);
        int unsigned s, slen, off, pos, addr, lim;
        bit          wr;
        logic [7:0]  sum;
        res = '0;
        if (it.byte_pos == 0) open_chunk(it);
        s    = cur_slot;
        off  = it.chunk_offset;
        pos  = it.byte_pos;
        slen = slot_len[s];
        if (cur_status == ST_INCOMPLETE && slot_used[s] && !slot_done[s]) begin
            if (it.chunk_len != 0) begin
                lim  = (slen - off < it.chunk_len) ? slen - off : it.chunk_len;
                wr   = pos < lim;
                addr = off + pos;
            end else if (slen <= chunk_bytes) begin
                wr   = pos < slen;
                addr = pos;
            end else begin
                lim  = (slen - off < chunk_bytes) ? slen - off : chunk_bytes;
                wr   = pos < lim;
                addr = off + pos;
            end
            if (wr && addr < MSG_MAX) begin
                buf_bytes[s * MSG_MAX + addr]   = it.data_byte;
                buf_written[s * MSG_MAX + addr] = 1'b1;
            end
        end
        if (!it.last_flag) return 1'b0;
        res.status = ST_INCOMPLETE;
        if (cur_status != ST_INCOMPLETE) begin
            res.status = cur_status;
        end else if (!slot_used[s]) begin
            res.status = ST_UNKNOWN;
        end else if (slot_done[s]) begin
            res.status = ST_COMPLETE;
        end else if (it.chunk_len != 0) begin
            if (off + it.chunk_len >= slen) begin
                slot_done[s] = 1'b1;
                res.status   = ST_COMPLETE;
            end
        end else if (slen <= chunk_bytes || off + chunk_bytes >= slen) begin
            // Final checksum chunk: all bytes but the last must add up to the last.
            sum = '0;
            for (int unsigned i = 0; i + 1 < slen && i < MSG_MAX; i++) begin
                sum += buf_bytes[s * MSG_MAX + i];
            end
            if (slen >= 1 && slen <= MSG_MAX && sum == buf_bytes[s * MSG_MAX + slen - 1]) begin
                slot_done[s] = 1'b1;
                res.status   = ST_COMPLETE;
            end else begin
                res.status = ST_BAD_SUM;
            end
        end
        if (slot_used[s]) res.length_out = slot_len[s];
        return 1'b1;
    endfunction

    // Predicts the result of one accepted item and updates the shadow state.
    function automatic bit reassemble_step(input t_in_item it, output t_result res);
        int s;
        res = '0;
        case (it.req_type)
            RT_SAVE: begin
                return save_byte(it, res);
            end
            RT_QUERY: begin
                s = lookup(it.msg_cmd, it.msg_index);
                if (s < 0) begin
                    res.status = ST_UNKNOWN;
                end else begin
                    res.status     = slot_done[s] ? ST_COMPLETE : ST_UNFINISHED;
                    res.length_out = slot_len[s];
                end
                return 1'b1;
            end
            RT_READ: begin
                s = lookup(it.msg_cmd, it.msg_index);
                if (s < 0) begin
                    res.status = ST_UNKNOWN;
                end else begin
                    res.length_out = slot_len[s];
                    if (!slot_done[s]) begin
                        res.status = ST_UNFINISHED;
                    end else begin
                        res.status = ST_COMPLETE;
                        if (it.byte_pos < slot_len[s]) begin
                            res.read_byte = buf_bytes[s * MSG_MAX + it.byte_pos];
                        end
                        if (it.last_flag) begin
                            slot_used[s] = 1'b0;
                            slot_done[s] = 1'b0;
                            slot_len[s]  = 0;
                        end
                    end
                end
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic t_in_item mk(input logic [1:0] req, input logic [7:0] cmd,
                                    input logic [15:0] idx, input int len, input int off,
                                    input int clen, input int pos, input logic [7:0] data,
                                    input bit last);
        t_in_item it;
        it.req_type     = req;
        it.msg_cmd      = cmd;
        it.msg_index    = idx;
        it.total_len    = len;
        it.chunk_offset = off;
        it.chunk_len    = clen;
        it.byte_pos     = pos;
        it.data_byte    = data;
        it.last_flag    = last;
        return it;
    endfunction

    // A read of a buffer byte that was never written is turned into a harmless one.
    function automatic t_in_item guard_read(input t_in_item it);
        int s;
        if (it.req_type != RT_READ) return it;
        s = lookup(it.msg_cmd, it.msg_index);
        if (s < 0 || !slot_done[s] || it.byte_pos >= slot_len[s]) return it;
        if (buf_written[s * MSG_MAX + it.byte_pos]) return it;
        if (slot_len[s] < MSG_MAX) begin
            it.byte_pos = MSG_MAX - 1;
        end else begin
            it.req_type = RT_QUERY;
        end
        return it;
    endfunction

    // Offers one item at the falling edge and returns once it has been accepted.
    task automatic offer(input t_in_item it, input bit typed, input t_result want);
        t_result res;
        while (!calm && $urandom_range(99) < 27) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        if (reassemble_step(it, res)) pending_results.push_back(typed ? want : res);
        push   <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (full);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send(input t_in_item it);
        offer(guard_read(it), 1'b0, '0);
    endtask

    task automatic write_chunk_size(input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_CHUNK_SIZE;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        chunk_bytes = value & 32'h1FFF;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic drain;
        push <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        // Trailing items without a result may still be in flight.
        repeat (60) @(negedge i_clk);
    endtask

    // Counted-mode message sent in chunks of random size, then maybe read back.
    task automatic counted_message(input int k);
        int         len, off, clen;
        logic [7:0] msg [];
        len = ($urandom_range(9) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 24);
        msg = new[len];
        foreach (msg[i]) msg[i] = $urandom;
        off = 0;
        while (off < len) begin
            clen = $urandom_range(1, len - off);
            for (int p = 0; p < clen; p++) begin
                send(mk(RT_SAVE, pool_cmd[k], pool_idx[k], len, off, clen, p, msg[off + p],
                        p == clen - 1));
            end
            off += clen;
        end
        if ($urandom_range(99) < 60) read_back(k, len);
    endtask

    // Checksum-mode message: the last byte carries the sum of the others, or in about one in five a wrong sum.
    task automatic checksum_message(input int k);
        int         len, off, n;
        logic [7:0] msg [];
        logic [7:0] sum;
        len = $urandom_range(1, 24);
        msg = new[len];
        sum = '0;
        for (int i = 0; i < len - 1; i++) begin
            msg[i] = $urandom;
            sum += msg[i];
        end
        msg[len - 1] = ($urandom_range(99) < 20) ? sum + 8'($urandom_range(1, 255)) : sum;
        off = 0;
        while (off < len) begin
            n = (len <= chunk_bytes) ? len : ((len - off < chunk_bytes) ? len - off : chunk_bytes);
            for (int p = 0; p < n; p++) begin
                send(mk(RT_SAVE, pool_cmd[k], pool_idx[k], len, off, 0, p, msg[off + p],
                        p == n - 1));
            end
            off += n;
        end
        if ($urandom_range(99) < 60) read_back(k, len);
    endtask

    task automatic read_back(input int k, input int len);
        send(mk(RT_QUERY, pool_cmd[k], pool_idx[k], 0, 0, 0, 0, $urandom, $urandom));
        for (int p = 0; p < len; p++) begin
            send(mk(RT_READ, pool_cmd[k], pool_idx[k], $urandom, $urandom, $urandom, p,
                    $urandom, p == len - 1));
        end
    endtask

    // Loose items with random fields; a checksum walk is never started from here.
    task automatic noise_item;
        t_in_item it;
        int       k;
        k  = $urandom_range(POOL_KEYS - 1);
        it = mk($urandom_range(3), pool_cmd[k], pool_idx[k], $urandom_range(1, 30),
                $urandom_range(3), $urandom_range(1, 8), $urandom_range(3), $urandom,
                $urandom_range(1));
        if ($urandom_range(1)) begin
            it.msg_cmd   = $urandom;
            it.msg_index = $urandom;
        end
        if ($urandom_range(9) == 0) it.total_len = $urandom_range(8191);
        if ($urandom_range(3) == 0) it.chunk_offset = $urandom_range(4095);
        if ($urandom_range(4) == 0) it.chunk_len = $urandom_range(8191);
        if ($urandom_range(3) == 0) it.byte_pos = $urandom_range(4095);
        if (it.req_type == RT_SAVE && it.last_flag && it.chunk_len == 0) it.chunk_len = 1;
        send(it);
    endtask

    task automatic random_phase(input int count);
        int stop, pick, k;
        stop = items_sent + count;
        while (items_sent < stop) begin
            calm = (items_sent % 1000) >= 600 && (items_sent % 1000) < 780;
            pick = $urandom_range(99);
            k    = $urandom_range(POOL_KEYS - 1);
            if (pick < 45) begin
                counted_message(k);
            end else if (pick < 70) begin
                checksum_message(k);
            end else if (pick < 85) begin
                read_back(k, $urandom_range(1, 6));
            end else begin
                repeat ($urandom_range(1, 4)) noise_item();
            end
        end
        calm = 1'b0;
    endtask

    // Result checker: each popped result against the oldest expectation.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && pop && !empty) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result: %p", o_result);
            end else begin
                want = pending_results.pop_front();
                if (o_result.status !== want.status || o_result.length_out !== want.length_out
                    || o_result.read_byte !== want.read_byte) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("Mismatch: expected status %0d length %0d byte %0h, got %0d %0d %0h",
                                 want.status, want.length_out, want.read_byte,
                                 o_result.status, o_result.length_out, o_result.read_byte);
                    end
                end
            end
        end
    end

    // Receiver: random stalls, and once a long hold-off so that the block fills up.
    always @(negedge i_clk) begin
        if (cycles >= 2500 && cycles < 3000) begin
            pop <= 1'b0;
        end else begin
            pop <= calm || ($urandom_range(99) >= 27);
        end
    end

    // Cycle counter and run limit.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Directed table, then random phases under several chunk sizes.
    initial begin
        t_row rows[$];
        int   phase_sizes [5];
        phase_sizes = '{1, 4096, 7, 0, 504};
        for (int s = 0; s < SLOTS; s++) begin
            slot_used[s] = 1'b0;
            slot_cmd[s]  = '0;
            slot_idx[s]  = '0;
            slot_len[s]  = 0;
            slot_done[s] = 1'b0;
        end
        foreach (buf_bytes[i]) begin
            buf_bytes[i]   = '0;
            buf_written[i] = 1'b0;
        end
        cur_slot    = '0;
        cur_status  = ST_INCOMPLETE;
        chunk_bytes = CHUNK_SIZE_RESET;
        for (int k = 0; k < POOL_KEYS; k++) begin
            pool_cmd[k] = $urandom;
            pool_idx[k] = $urandom;
        end
        // Keys used by the directed rows join the pool so their slots can be freed.
        pool_cmd[0] = 8'd1; pool_idx[0] = 16'd1;
        pool_cmd[1] = 8'd2; pool_idx[1] = 16'd2;
        pool_cmd[2] = 8'd3; pool_idx[2] = 16'd3;
        pool_cmd[3] = 8'd4; pool_idx[3] = 16'd4;
        pool_cmd[4] = 8'd5; pool_idx[4] = 16'd5;

        rows.push_back('{mk(RT_QUERY, 8'd0, 16'd0, 0, 0, 0, 0, 8'h00, 1'b0), 1'b1,
                         '{ST_UNKNOWN, 13'd0, 8'h00}});
        rows.push_back('{mk(RT_READ, 8'd0, 16'd0, 0, 0, 0, 0, 8'h00, 1'b1), 1'b1,
                         '{ST_UNKNOWN, 13'd0, 8'h00}});
        // Lengths above the buffer size.
        rows.push_back('{mk(RT_SAVE, 8'hFF, 16'hFFFF, 4097, 0, 1, 0, 8'h00, 1'b1), 1'b1,
                         '{ST_LEN_MISM, 13'd0, 8'h00}});
        rows.push_back('{mk(RT_SAVE, 8'hFF, 16'hFFFF, 8191, 4095, 8191, 0, 8'h00, 1'b1), 1'b1,
                         '{ST_LEN_MISM, 13'd0, 8'h00}});
        // Zero length and offset past the end.
        rows.push_back('{mk(RT_SAVE, 8'd0, 16'd0, 0, 0, 1, 0, 8'h00, 1'b1), 1'b1,
                         '{ST_BAD_OFFSET, 13'd0, 8'h00}});
        rows.push_back('{mk(RT_SAVE, 8'd1, 16'd1, 4, 4095, 1, 0, 8'h00, 1'b1), 1'b1,
                         '{ST_BAD_OFFSET, 13'd4, 8'h00}});
        // Two-byte counted message, query, read back and free.
        rows.push_back('{mk(RT_SAVE, 8'h80, 16'h8000, 2, 0, 2, 0, 8'hFF, 1'b0), 1'b0, '0});
        rows.push_back('{mk(RT_SAVE, 8'h80, 16'h8000, 2, 0, 2, 1, 8'h00, 1'b1), 1'b1,
                         '{ST_COMPLETE, 13'd2, 8'h00}});
        rows.push_back('{mk(RT_QUERY, 8'h80, 16'h8000, 0, 0, 0, 0, 8'h00, 1'b0), 1'b1,
                         '{ST_COMPLETE, 13'd2, 8'h00}});
        rows.push_back('{mk(RT_READ, 8'h80, 16'h8000, 0, 0, 0, 0, 8'h00, 1'b0), 1'b1,
                         '{ST_COMPLETE, 13'd2, 8'hFF}});
        rows.push_back('{mk(RT_READ, 8'h80, 16'h8000, 0, 0, 0, 4095, 8'h00, 1'b1), 1'b1,
                         '{ST_COMPLETE, 13'd2, 8'h00}});
        rows.push_back('{mk(RT_QUERY, 8'h80, 16'h8000, 0, 0, 0, 0, 8'h00, 1'b0), 1'b1,
                         '{ST_UNKNOWN, 13'd0, 8'h00}});
        // Unfinished message and a length mismatch against it.
        rows.push_back('{mk(RT_SAVE, 8'd2, 16'd2, 3, 0, 1, 0, 8'hAA, 1'b1), 1'b1,
                         '{ST_INCOMPLETE, 13'd3, 8'h00}});
        rows.push_back('{mk(RT_QUERY, 8'd2, 16'd2, 0, 0, 0, 0, 8'h00, 1'b0), 1'b1,
                         '{ST_UNFINISHED, 13'd3, 8'h00}});
        rows.push_back('{mk(RT_READ, 8'd2, 16'd2, 0, 0, 0, 0, 8'h00, 1'b1), 1'b1,
                         '{ST_UNFINISHED, 13'd3, 8'h00}});
        rows.push_back('{mk(RT_SAVE, 8'd2, 16'd2, 5, 0, 1, 0, 8'h00, 1'b1), 1'b1,
                         '{ST_LEN_MISM, 13'd3, 8'h00}});
        // Checksum mode: a good sum, a bad sum, then a save to a finished message.
        rows.push_back('{mk(RT_SAVE, 8'd3, 16'd3, 3, 0, 0, 0, 8'h10, 1'b0), 1'b0, '0});
        rows.push_back('{mk(RT_SAVE, 8'd3, 16'd3, 3, 0, 0, 1, 8'h20, 1'b0), 1'b0, '0});
        rows.push_back('{mk(RT_SAVE, 8'd3, 16'd3, 3, 0, 0, 2, 8'h30, 1'b1), 1'b1,
                         '{ST_COMPLETE, 13'd3, 8'h00}});
        rows.push_back('{mk(RT_SAVE, 8'd4, 16'd4, 2, 0, 0, 0, 8'h05, 1'b0), 1'b0, '0});
        rows.push_back('{mk(RT_SAVE, 8'd4, 16'd4, 2, 0, 0, 1, 8'h06, 1'b1), 1'b1,
                         '{ST_BAD_SUM, 13'd2, 8'h00}});
        rows.push_back('{mk(RT_SAVE, 8'd3, 16'd3, 3, 0, 0, 0, 8'h00, 1'b1), 1'b1,
                         '{ST_COMPLETE, 13'd3, 8'h00}});
        rows.push_back('{mk(2'd3, 8'd3, 16'd3, 3, 0, 0, 0, 8'h00, 1'b1), 1'b0, '0});
        // Full-length message finished by its very last byte.
        rows.push_back('{mk(RT_SAVE, 8'd5, 16'd5, 4096, 4095, 1, 0, 8'hEE, 1'b1), 1'b1,
                         '{ST_COMPLETE, 13'd4096, 8'h00}});
        rows.push_back('{mk(RT_READ, 8'd5, 16'd5, 0, 0, 0, 4095, 8'h00, 1'b0), 1'b1,
                         '{ST_COMPLETE, 13'd4096, 8'hEE}});
        // Chunk whose slot completes, then is freed, while the chunk is still open.
        rows.push_back('{mk(RT_SAVE, 8'd6, 16'd6, 2, 0, 2, 0, 8'h01, 1'b0), 1'b0, '0});
        rows.push_back('{mk(RT_SAVE, 8'd6, 16'd6, 2, 0, 2, 1, 8'h02, 1'b1), 1'b0, '0});
        rows.push_back('{mk(RT_SAVE, 8'd9, 16'd9, 2, 0, 2, 1, 8'h03, 1'b1), 1'b0, '0});
        rows.push_back('{mk(RT_READ, 8'd6, 16'd6, 0, 0, 0, 0, 8'h00, 1'b1), 1'b0, '0});
        rows.push_back('{mk(RT_SAVE, 8'd9, 16'd9, 2, 0, 1, 1, 8'h04, 1'b1), 1'b0, '0});

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (rows[r]) offer(rows[r].item, rows[r].typed, rows[r].want);
        random_phase(RANDOM_ITEMS / 6);
        foreach (phase_sizes[p]) begin
            drain();
            write_chunk_size(phase_sizes[p] == 0 ? $urandom_range(2, 30) : phase_sizes[p]);
            random_phase(RANDOM_ITEMS / 6);
        end
        push <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
